// ----- rtl/rrc_pkg.sv -----
// ----------------------------------------------------------------------------
// rrc_pkg: shared types and constants for the rotated rectangle corner unit
// Holds the CORDIC stage count, the arctangent table in binary-angle units,
// and the records that travel down the rotation chain.
// ----------------------------------------------------------------------------
package rrc_pkg;

  // Rotation chain depth, usable from 8 to ATAN_ENTRIES
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 30;
  localparam int STAGE_W       = $clog2(ATAN_ENTRIES);

  // CORDIC gain compensation, Q2.30
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  // atan(2^-i) with a full turn equal to 2^32
  localparam logic signed [31:0] ATAN_BAM [ATAN_ENTRIES] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
    32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
    32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
  };

  // Quadrant of the reduced angle
  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_e;

  // Rectangle geometry carried alongside the rotation
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
  } geom_t;

  // One record of the rotation chain
  typedef struct packed {
    quad_e              quad;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    geom_t              geom;
  } crd_t;

endpackage

// ----- rtl/rrc_bam.sv -----
// ----------------------------------------------------------------------------
// rrc_bam: degrees to binary angle
// Turns a Q16.16 angle in degrees into a 32-bit binary angle, rounded, by a
// constant division by 360 done one byte per step over three stages, then
// splits off the quadrant and seeds the first rotation cell.
// ----------------------------------------------------------------------------
module rrc_bam (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_valid_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  size_x_i,
  input  logic signed [31:0]  size_y_i,
  input  logic signed [31:0]  angle_deg_i,
  output logic                vld_o,
  output rrc_pkg::crd_t       crd_o
);
  import rrc_pkg::*;

  // Offset that makes the numerator positive without moving the result mod 2^32
  localparam logic [47:0] NUM_BIAS = 48'd45 << 39;
  localparam logic [47:0] NUM_HALF = 48'd22;

  // One long-division step by 45: returns {quotient byte, remainder}
  function automatic logic [13:0] div45_step(input logic [5:0] rem,
                                             input logic [7:0] octet);
    logic [13:0] v;
    logic [24:0] prod;
    logic [7:0]  q0;
    logic [13:0] r0;
    v    = {rem, octet};
    prod = 25'(v) * 25'd1456;
    q0   = prod[23:16];
    r0   = v - 14'(q0) * 14'd45;
    if (r0 >= 14'd45) begin
      q0 = q0 + 8'd1;
      r0 = r0 - 14'd45;
    end
    return {q0, r0[5:0]};
  endfunction

  logic        s0_vld_q, s1_vld_q, s2_vld_q, s3_vld_q;
  logic [47:0] s0_num_q;
  logic [47:0] num_d;
  geom_t       s0_geom_q, s1_geom_q, s2_geom_q;
  logic [31:0] s1_num_q;
  logic [5:0]  s1_rem_q, s2_rem_q;
  logic [15:0] s2_num_q, s2_hi_q;
  logic [13:0] st1a, st1b, st2a, st2b, st3a, st3b;
  logic [31:0] bam;
  crd_t        crd_d, crd_q;

  // Build angle*8192 + 22 plus bias, which is (angle*65536 + 180) / 8 floored
  assign num_d = {{3{angle_deg_i[31]}}, angle_deg_i, 13'd0} + NUM_HALF + NUM_BIAS;

  // Divide the top two bytes; their quotient lies above bit 31 and is dropped
  assign st1a = div45_step(6'd0, s0_num_q[47:40]);
  assign st1b = div45_step(st1a[5:0], s0_num_q[39:32]);

  // Produce the upper half of the binary angle
  assign st2a = div45_step(s1_rem_q, s1_num_q[31:24]);
  assign st2b = div45_step(st2a[5:0], s1_num_q[23:16]);

  // Produce the lower half and seed the rotation
  assign st3a = div45_step(s2_rem_q, s2_num_q[15:8]);
  assign st3b = div45_step(st3a[5:0], s2_num_q[7:0]);
  assign bam  = {s2_hi_q, st3a[13:6], st3b[13:6]};

  always_comb begin
    crd_d      = '0;
    crd_d.quad = quad_e'(bam[31:30] + {1'b0, bam[29]});
    crd_d.x    = CORDIC_GAIN;
    crd_d.y    = '0;
    crd_d.z    = {{2{bam[29]}}, bam[29:0]};
    crd_d.geom = s2_geom_q;
  end

  // Advance beat valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s0_vld_q <= in_valid_i;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_num_q  <= num_d;
      s0_geom_q <= '{pos_x: pos_x_i, pos_y: pos_y_i, size_x: size_x_i, size_y: size_y_i};
      s1_num_q  <= s0_num_q[31:0];
      s1_rem_q  <= st1b[5:0];
      s1_geom_q <= s0_geom_q;
      s2_num_q  <= s1_num_q[15:0];
      s2_hi_q   <= {st2a[13:6], st2b[13:6]};
      s2_rem_q  <= st2b[5:0];
      s2_geom_q <= s1_geom_q;
      crd_q     <= crd_d;
    end
  end

  assign vld_o = s3_vld_q;
  assign crd_o = crd_q;

endmodule

// ----- rtl/rrc_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// rrc_cordic_cell: one CORDIC rotation step
// Rotates the vector toward the residual angle by atan(2^-i) and hands the
// record to the next cell on every enabled clock.
// ----------------------------------------------------------------------------
module rrc_cordic_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [rrc_pkg::STAGE_W-1:0]   stage_i,
  input  logic                          vld_i,
  input  rrc_pkg::crd_t                 crd_i,
  output logic                          vld_o,
  output rrc_pkg::crd_t                 crd_o
);
  import rrc_pkg::*;

  logic               vld_q;
  crd_t               crd_d, crd_q;
  logic signed [31:0] xs, ys, atan;

  // Rotate one step, direction set by the sign of the residual angle
  always_comb begin
    xs    = $signed(crd_i.x) >>> stage_i;
    ys    = $signed(crd_i.y) >>> stage_i;
    atan  = ATAN_BAM[stage_i];
    crd_d = crd_i;
    if (!crd_i.z[31]) begin
      crd_d.x = crd_i.x - ys;
      crd_d.y = crd_i.y + xs;
      crd_d.z = crd_i.z - atan;
    end else begin
      crd_d.x = crd_i.x + ys;
      crd_d.y = crd_i.y - xs;
      crd_d.z = crd_i.z + atan;
    end
  end

  // Hold beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Hold record
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      crd_q <= crd_d;
    end
  end

  assign vld_o = vld_q;
  assign crd_o = crd_q;

endmodule

// ----- rtl/rrc_corner.sv -----
// ----------------------------------------------------------------------------
// rrc_corner: corner arithmetic and result serializer
// Rounds sine and cosine, applies the quadrant, forms the shared products
// once per item and sends the four corners out one beat at a time.
// ----------------------------------------------------------------------------
module rrc_corner (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  rrc_pkg::crd_t       crd_i,
  output logic                adv_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          corner_o,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic                last_corner_o
);
  import rrc_pkg::*;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  // Clamp to the signed Q16.16 range
  function automatic logic [31:0] sat32(input logic [36:0] v);
    logic [31:0] r;
    if (v[36:31] == {6{v[36]}}) begin
      r = v[31:0];
    end else if (v[36]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  logic               adv, out_load, ser_free, load_item;
  logic signed [32:0] c_full, s_full;
  logic signed [18:0] c_raw, s_raw, c_d, s_d;

  logic               p1_vld_q;
  logic signed [18:0] p1_c_q, p1_s_q;
  geom_t              p1_geom_q;

  logic signed [33:0] cx_sum, cy_sum;
  logic               p2_vld_q;
  logic signed [50:0] p2_pcx_q, p2_psy_q, p2_psx_q, p2_pcy_q;
  logic signed [49:0] p2_cx_q, p2_cy_q;

  logic signed [51:0] sum_a, sum_b, sum_e, sum_f;
  logic signed [51:0] it_a_q, it_b_q, it_e_q, it_f_q;
  logic signed [49:0] it_cx_q, it_cy_q;

  logic               busy_q, ovld_q;
  logic [1:0]         idx_q;
  logic signed [51:0] sel_x, sel_y;
  logic               sub_x, sub_y;
  logic signed [53:0] nx, ny;
  logic [1:0]         corner_q;
  logic [31:0]        out_x_q, out_y_q;
  logic               last_q;

  // Round Q2.30 to 16 fractional bits and rotate by the quadrant
  assign c_full = $signed({crd_i.x[31], crd_i.x}) + 33'sd8192;
  assign s_full = $signed({crd_i.y[31], crd_i.y}) + 33'sd8192;
  assign c_raw  = c_full[32:14];
  assign s_raw  = s_full[32:14];

  always_comb begin
    case (crd_i.quad)
      QUAD_I: begin
        c_d = c_raw;
        s_d = s_raw;
      end
      QUAD_II: begin
        c_d = -s_raw;
        s_d = c_raw;
      end
      QUAD_III: begin
        c_d = -c_raw;
        s_d = -s_raw;
      end
      QUAD_IV: begin
        c_d = s_raw;
        s_d = -c_raw;
      end
      default: begin
        c_d = c_raw;
        s_d = s_raw;
      end
    endcase
  end

  // Doubled center plus the rounding half, scaled by 2^16
  assign cx_sum = $signed({p1_geom_q.pos_x[31], p1_geom_q.pos_x, 1'b0})
                + $signed({{2{p1_geom_q.size_x[31]}}, p1_geom_q.size_x}) + 34'sd1;
  assign cy_sum = $signed({p1_geom_q.pos_y[31], p1_geom_q.pos_y, 1'b0})
                + $signed({{2{p1_geom_q.size_y[31]}}, p1_geom_q.size_y}) + 34'sd1;

  // Combine products into the four shared offsets
  assign sum_a = p2_pcx_q + p2_psy_q;
  assign sum_b = p2_pcx_q - p2_psy_q;
  assign sum_e = p2_psx_q + p2_pcy_q;
  assign sum_f = p2_psx_q - p2_pcy_q;

  // Handshake: serializer frees up as the fourth beat leaves
  assign out_load  = !ovld_q || !out_stall_i;
  assign ser_free  = !busy_q || (out_load && (idx_q == CORNER_BL));
  assign adv       = !p2_vld_q || ser_free;
  assign load_item = adv && p2_vld_q;

  // Pick the offsets and signs of the current corner
  always_comb begin
    case (idx_q)
      CORNER_TL: begin
        sel_x = it_b_q; sub_x = 1'b1;
        sel_y = it_e_q; sub_y = 1'b1;
      end
      CORNER_TR: begin
        sel_x = it_a_q; sub_x = 1'b0;
        sel_y = it_f_q; sub_y = 1'b0;
      end
      CORNER_BR: begin
        sel_x = it_b_q; sub_x = 1'b0;
        sel_y = it_e_q; sub_y = 1'b0;
      end
      CORNER_BL: begin
        sel_x = it_a_q; sub_x = 1'b1;
        sel_y = it_f_q; sub_y = 1'b1;
      end
      default: begin
        sel_x = it_b_q; sub_x = 1'b1;
        sel_y = it_e_q; sub_y = 1'b1;
      end
    endcase
  end

  assign nx = sub_x ? (it_cx_q - sel_x) : (it_cx_q + sel_x);
  assign ny = sub_y ? (it_cy_q - sel_y) : (it_cy_q + sel_y);

  // Control: stage valids, serializer count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      busy_q   <= 1'b0;
      idx_q    <= CORNER_TL;
      ovld_q   <= 1'b0;
    end else begin
      if (adv) begin
        p1_vld_q <= vld_i;
        p2_vld_q <= p1_vld_q;
      end
      if (out_load) begin
        ovld_q <= busy_q;
      end
      if (load_item) begin
        busy_q <= 1'b1;
        idx_q  <= CORNER_TL;
      end else if (out_load && busy_q) begin
        busy_q <= (idx_q != CORNER_BL);
        idx_q  <= idx_q + 2'd1;
      end
    end
  end

  // Payload: trig, products, item, output beat
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_c_q    <= c_d;
      p1_s_q    <= s_d;
      p1_geom_q <= crd_i.geom;
      p2_pcx_q  <= p1_c_q * $signed(p1_geom_q.size_x);
      p2_psy_q  <= p1_s_q * $signed(p1_geom_q.size_y);
      p2_psx_q  <= p1_s_q * $signed(p1_geom_q.size_x);
      p2_pcy_q  <= p1_c_q * $signed(p1_geom_q.size_y);
      p2_cx_q   <= {cx_sum, 16'd0};
      p2_cy_q   <= {cy_sum, 16'd0};
    end
    if (load_item) begin
      it_a_q  <= sum_a;
      it_b_q  <= sum_b;
      it_e_q  <= sum_e;
      it_f_q  <= sum_f;
      it_cx_q <= p2_cx_q;
      it_cy_q <= p2_cy_q;
    end
    if (out_load && busy_q) begin
      corner_q <= idx_q;
      out_x_q  <= sat32(nx[53:17]);
      out_y_q  <= sat32(ny[53:17]);
      last_q   <= (idx_q == CORNER_BL);
    end
  end

  assign adv_o         = adv;
  assign out_valid_o   = ovld_q;
  assign corner_o      = corner_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign last_corner_o = last_q;

endmodule

// ----- rtl/rotated_rectangle_corners.sv -----
// One rectangle in, four corners out: each accepted beat carries a top-left
// position, a size and an angle in degrees (all signed Q16.16), and yields
// four result beats (top-left, top-right, bottom-right, bottom-left) rotated
// about the center, the fourth with last_corner_o set. A full pipeline
// takes a new rectangle only as the fourth corner of the previous one
// enters the single output register that all four corner beats share;
// a new rectangle is taken while the previous one's corners are still
// leaving. The first corner passes the input register, the three division
// stages of the degree-to-binary-angle conversion, one register per
// rotation cell, the trig rounding and product stages, the corner
// serializer and the output register. The pipeline moves as a whole:
// while the product stage holds a rectangle that the busy serializer
// cannot take, every stage holds and in_stall_o is raised; an empty
// product stage or a free serializer lets every stage advance.
// ----------------------------------------------------------------------------
// rotated_rectangle_corners: rotated rectangle corner generator
// Angle reduction, a chain of CORDIC cells and a corner serializer.
// ----------------------------------------------------------------------------
module rotated_rectangle_corners (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  size_x_i,
  input  logic signed [31:0]  size_y_i,
  input  logic signed [31:0]  angle_deg_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          corner_o,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic                last_corner_o
);
  import rrc_pkg::*;

  logic adv;
  logic vld_chain [CORDIC_STAGES+1];
  crd_t crd_chain [CORDIC_STAGES+1];

  // Convert the angle and seed the chain
  rrc_bam u_bam (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .in_valid_i  (in_valid_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .size_x_i    (size_x_i),
    .size_y_i    (size_y_i),
    .angle_deg_i (angle_deg_i),
    .vld_o       (vld_chain[0]),
    .crd_o       (crd_chain[0])
  );

  // Rotate through the chain of cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    rrc_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .stage_i (STAGE_W'(i)),
      .vld_i   (vld_chain[i]),
      .crd_i   (crd_chain[i]),
      .vld_o   (vld_chain[i+1]),
      .crd_o   (crd_chain[i+1])
    );
  end

  // Form and send the corners
  rrc_corner u_corner (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vld_i         (vld_chain[CORDIC_STAGES]),
    .crd_i         (crd_chain[CORDIC_STAGES]),
    .adv_o         (adv),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .corner_o      (corner_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .last_corner_o (last_corner_o)
  );

  assign in_stall_o = !adv;

endmodule
